// ===== rtl/core/jsu_pkg.sv =====
// ============================================================================
// jsu_pkg
// Shared types and constants for the JSON string unescape / UTF-8 core.
// ============================================================================
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // Capacity after reset
    localparam logic [15:0] CAP_RESET = 16'd32;

    // Most results one text byte can cause
    localparam int unsigned MAX_RES = 4;

    // Decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    // Decoder state carried between text bytes
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hex_cnt;
        logic [15:0] code;
        logic [15:0] count;
    } t_state;

    // One result
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  out_kind;
        logic [15:0] out_length;
    } t_result;

    // All results of one text byte
    typedef struct packed {
        logic [2:0]                  cnt;
        t_result [MAX_RES-1:0]       res;
    } t_bundle;

endpackage

// ===== rtl/core/jsu_in_if.sv =====
// ============================================================================
// jsu_in_if
// Text byte channel: valid/ready handshake carrying one input byte.
// ============================================================================
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/jsu_out_if.sv =====
// ============================================================================
// jsu_out_if
// Result channel: valid/ready handshake carrying one decoded result.
// ============================================================================
interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [15:0] out_length;
    logic        last;

    modport source (output valid, output out_byte, output out_kind,
                    output out_length, output last, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input out_length, input last, output ready);
endinterface

// ===== rtl/core/jsu_cfg.sv =====
// ============================================================================
// jsu_cfg
// APB-style register port holding the destination capacity.
// ============================================================================
module jsu_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_capacity
);

    logic [15:0] r_capacity;
    logic        wr_en;

    // Only one register: a write at any address goes to capacity
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= jsu_pkg::CAP_RESET;
        end else if (wr_en) begin
            r_capacity <= pwdata[15:0];
        end
    end

    // Read-back of capacity at byte address 0
    assign prdata     = (paddr == 2'd0) ? {16'd0, r_capacity} : 32'd0;
    assign o_capacity = r_capacity;

endmodule

// ===== rtl/core/jsu_decode.sv =====
// ============================================================================
// jsu_decode
// Per-byte decode: next state and the full set of results for one text byte.
// ============================================================================
module jsu_decode (
    input  logic [7:0]       i_byte,
    input  jsu_pkg::t_state  i_state,
    input  logic [15:0]      i_capacity,
    output jsu_pkg::t_state  o_state,
    output jsu_pkg::t_bundle o_bundle
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Hex digit value, bit 4 set when the byte is a digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    logic [4:0]  hv;
    logic [15:0] code_sh;
    logic        fits1;
    logic        fits2;
    logic        fits3;

    assign hv      = hex_val(i_byte);
    assign code_sh = {i_state.code[11:0], hv[3:0]};
    assign fits1   = ({1'b0, i_state.count} + 17'd1) < {1'b0, i_capacity};
    assign fits2   = ({1'b0, i_state.count} + 17'd2) < {1'b0, i_capacity};
    assign fits3   = ({1'b0, i_state.count} + 17'd3) < {1'b0, i_capacity};

    always_comb begin
        jsu_pkg::t_state nxt;
        logic        do_raw;
        logic        do_enc;
        logic [7:0]  raw_b;
        logic [15:0] enc_c;
        logic        end_en;
        logic [1:0]  end_kind;
        logic [1:0]  st_len;
        logic [7:0]  st_b [3];

        nxt      = i_state;
        do_raw   = 1'b0;
        do_enc   = 1'b0;
        raw_b    = i_byte;
        enc_c    = i_state.code;
        end_en   = 1'b0;
        end_kind = jsu_pkg::KIND_FAIL;
        st_len   = 2'd0;
        st_b[0]  = 8'd0;
        st_b[1]  = 8'd0;
        st_b[2]  = 8'd0;

        // Phase handling
        case (i_state.phase)
            jsu_pkg::PH_IDLE: begin
                if (i_byte == CH_QUOTE) begin
                    nxt.phase = jsu_pkg::PH_STR;
                    nxt.count = 16'd0;
                end else if (!(i_byte == CH_SPACE || i_byte == CH_TAB ||
                               i_byte == CH_LF || i_byte == CH_CR)) begin
                    end_en = 1'b1;
                end
            end
            jsu_pkg::PH_STR: begin
                if (i_byte == CH_NUL) begin
                    end_en = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    end_en   = 1'b1;
                    end_kind = jsu_pkg::KIND_OK;
                end else if (i_byte == CH_BSL) begin
                    nxt.phase = jsu_pkg::PH_ESC;
                end else begin
                    do_raw = 1'b1;
                end
            end
            jsu_pkg::PH_ESC: begin
                nxt.phase = jsu_pkg::PH_STR;
                if (i_byte == CH_NUL) begin
                    // pending backslash stored as itself
                    do_raw = 1'b1;
                    raw_b  = CH_BSL;
                    end_en = 1'b1;
                end else if (i_byte == CH_N) begin
                    do_raw = 1'b1;
                    raw_b  = CH_LF;
                end else if (i_byte == CH_T) begin
                    do_raw = 1'b1;
                    raw_b  = CH_TAB;
                end else if (i_byte == CH_R) begin
                    do_raw = 1'b1;
                    raw_b  = CH_CR;
                end else if (i_byte == CH_B) begin
                    do_raw = 1'b1;
                    raw_b  = 8'h08;
                end else if (i_byte == CH_F) begin
                    do_raw = 1'b1;
                    raw_b  = 8'h0c;
                end else if (i_byte == CH_U) begin
                    nxt.phase   = jsu_pkg::PH_HEX;
                    nxt.hex_cnt = 2'd0;
                    nxt.code    = 16'd0;
                end else begin
                    do_raw = 1'b1;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (i_byte == CH_NUL) begin
                    // partial code still goes out
                    do_enc = 1'b1;
                    end_en = 1'b1;
                end else if (!hv[4]) begin
                    end_en = 1'b1;
                end else if (i_state.hex_cnt == 2'd3) begin
                    do_enc      = 1'b1;
                    enc_c       = code_sh;
                    nxt.phase   = jsu_pkg::PH_STR;
                    nxt.hex_cnt = 2'd0;
                    nxt.code    = 16'd0;
                end else begin
                    nxt.code    = code_sh;
                    nxt.hex_cnt = i_state.hex_cnt + 2'd1;
                end
            end
            default: begin
                nxt.phase = jsu_pkg::PH_IDLE;
            end
        endcase

        // Byte store, or UTF-8 encoding dropped whole when it does not fit
        if (do_raw) begin
            st_len  = fits1 ? 2'd1 : 2'd0;
            st_b[0] = raw_b;
        end else if (do_enc) begin
            if (enc_c[15:7] == 9'd0) begin
                st_len  = fits1 ? 2'd1 : 2'd0;
                st_b[0] = enc_c[7:0];
            end else if (enc_c[15:11] == 5'd0) begin
                st_len  = fits2 ? 2'd2 : 2'd0;
                st_b[0] = {3'b110, enc_c[10:6]};
                st_b[1] = {2'b10, enc_c[5:0]};
            end else begin
                st_len  = fits3 ? 2'd3 : 2'd0;
                st_b[0] = {4'b1110, enc_c[15:12]};
                st_b[1] = {2'b10, enc_c[11:6]};
                st_b[2] = {2'b10, enc_c[5:0]};
            end
        end

        nxt.count = nxt.count + 16'(st_len);

        // End result returns to waiting for an opening quote
        if (end_en) begin
            nxt.phase   = jsu_pkg::PH_IDLE;
            nxt.hex_cnt = 2'd0;
            nxt.code    = 16'd0;
            nxt.count   = 16'd0;
        end

        // Result slots: stored bytes first, then the end result
        o_bundle.cnt = {1'b0, st_len} + {2'b00, end_en};
        for (int j = 0; j < 4; j++) begin
            o_bundle.res[j] = '0;
            if (j < 3 && 2'(j) < st_len) begin
                o_bundle.res[j].out_byte   = st_b[j % 3];
                o_bundle.res[j].out_kind   = jsu_pkg::KIND_BYTE;
                o_bundle.res[j].out_length = i_state.count + 16'(j + 1);
            end else if (end_en && 3'(j) == {1'b0, st_len}) begin
                o_bundle.res[j].out_byte   = 8'd0;
                o_bundle.res[j].out_kind   = end_kind;
                o_bundle.res[j].out_length = i_state.count + 16'(st_len);
            end
        end

        o_state = nxt;
    end

endmodule

// ===== rtl/core/jsu_out_buf.sv =====
// ============================================================================
// jsu_out_buf
// Result register: holds the results of one text byte and hands them out
// one transaction per cycle while the receiver is ready.
// ============================================================================
module jsu_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_can_take,
    jsu_out_if.source        o_out
);

    jsu_pkg::t_bundle r_bund;
    logic [1:0]       r_idx;
    logic             r_busy;
    logic             is_last;
    logic             take;
    logic             fin;

    assign is_last    = ({1'b0, r_idx} + 3'd1) == r_bund.cnt;
    assign take       = r_busy && o_out.ready;
    assign fin        = take && is_last;
    assign o_can_take = !r_busy || fin;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bund <= i_bundle;
        end
    end

    assign o_out.valid      = r_busy;
    assign o_out.out_byte   = r_bund.res[r_idx].out_byte;
    assign o_out.out_kind   = r_bund.res[r_idx].out_kind;
    assign o_out.out_length = r_bund.res[r_idx].out_length;
    assign o_out.last       = is_last;

`ifndef SYNTHESIS
    // index never runs past the results held
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < r_bund.cnt))
        else $error("result index beyond held count");
    // a held set is never empty
    a_cnt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_bund.cnt != 3'd0))
        else $error("empty result set held");
    // last transaction without reload frees the buffer
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && !i_load) |=> !r_busy)
        else $error("buffer not freed after last result");
`endif

endmodule

// ===== rtl/core/json_string_unescape_utf8_core.sv =====
// ============================================================================
// json_string_unescape_utf8_core
// JSON string decoder: whitespace skip, escape resolution, \u to UTF-8,
// capacity-limited storage, one text byte per cycle while the result register can take it.
// ============================================================================
//
//  Channel   Dir  Handshake                 Payload
//  i_in      in   valid/ready               in_byte
//  o_out     out  valid/ready               out_byte, out_kind, out_length, last
//  APB       in   psel/penable/pwrite       paddr, pwdata -> capacity
//
//  A text byte is decoded in the cycle it is taken; its results (up to four)
//  sit in the result register and leave one transaction per cycle while o_out is ready.
//  A byte giving no result leaves the result register untouched; one giving
//  results holds off the input while the result register drains.
//  i_in.ready is high when the result register is empty or its last result
//  leaves in this cycle. Reset is synchronous, active low; capacity resets to 32.
//
module json_string_unescape_utf8_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    jsu_pkg::t_state  r_state;
    jsu_pkg::t_state  n_state;
    jsu_pkg::t_bundle bundle;
    logic [15:0]      capacity;
    logic             can_take;
    logic             accept;

    jsu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    jsu_decode u_dec (
        .i_byte     (i_in.in_byte),
        .i_state    (r_state),
        .i_capacity (capacity),
        .o_state    (n_state),
        .o_bundle   (bundle)
    );

    jsu_out_buf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && bundle.cnt != 3'd0),
        .i_bundle   (bundle),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= jsu_pkg::PH_IDLE;
            r_state.hex_cnt <= 2'd0;
            r_state.code    <= 16'd0;
            r_state.count   <= 16'd0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // outside a string nothing is gathered or counted
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == jsu_pkg::PH_IDLE) |->
            (r_state.count == 16'd0 && r_state.code == 16'd0 &&
             r_state.hex_cnt == 2'd0))
        else $error("stale state outside a string");
    // digit count only moves inside a \u escape
    a_hex_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hex_cnt != 2'd0) |-> (r_state.phase == jsu_pkg::PH_HEX))
        else $error("hex digits counted outside escape");
    // opening quote enters the string
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state.phase == jsu_pkg::PH_IDLE && i_in.in_byte == 8'h22)
            |=> (r_state.phase == jsu_pkg::PH_STR))
        else $error("opening quote not taken");
`endif

endmodule

// ===== bench/tb_json_string_unescape_utf8_core.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_core
// Self-checking bench for the JSON string unescape / UTF-8 core. Text bytes
// go in over a valid/ready channel, bursty in some phases, and decoded results
// are drained by a stalling receiver. A scoreboard works out the expected results
// of every accepted byte and checks each result transaction in order. Capacity is
// rewritten over APB between phases, once all owed results have drained.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Text bytes with a meaning to the decoder
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_U      = "u";

    localparam logic [1:0] CAPACITY_ADDR = 2'd0;
    localparam int         PHASE_BYTES   = 4;
    localparam int         LONG_HOLD     = 120;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [15:0] length;
        logic        last;
    } t_out_item;

    typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_DENSE} t_rx_mode;
    typedef enum int {TOK_PLAIN, TOK_CTRL_ESC, TOK_OTHER_ESC, TOK_HEX} t_token;
    typedef enum int {
        END_CLOSE, END_NUL, END_ESC_NUL, END_HEX_NUL, END_BAD_HEX
    } t_string_end;

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'(8'("0"));
        if (b >= "a" && b <= "f") return int'(b) - int'(8'("a")) + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'(8'("A")) + 10;
        return -1;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: decoder state copy plus the queue of results still owed
    // ------------------------------------------------------------------------
    class t_scoreboard;
        jsu_pkg::t_phase phase;
        logic [1:0]      hex_cnt;
        logic [15:0]     code;
        logic [15:0]     stored;
        logic [15:0]     capacity;
        t_out_item       expected_out[$];
        t_out_item       batch[$];
        int              errors;

        function void reset_state();
            capacity = jsu_pkg::CAP_RESET;
            phase    = jsu_pkg::PH_IDLE;
            hex_cnt  = '0;
            code     = '0;
            stored   = '0;
        endfunction

        function void set_capacity(logic [15:0] value);
            capacity = value;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void emit(logic [7:0] b, logic [1:0] kind);
            t_out_item r;
            r.data   = b;
            r.kind   = kind;
            r.length = stored;
            r.last   = 1'b0;
            batch.push_back(r);
        endfunction

        function void store_byte(logic [7:0] b);
            if (int'(stored) + 1 < int'(capacity)) begin
                stored++;
                emit(b, jsu_pkg::KIND_BYTE);
            end
        endfunction

        // UTF-8 encode a 16-bit code, dropped whole when it does not fit
        function void store_code(logic [15:0] c);
            if (c < 16'h0080) begin
                store_byte(c[7:0]);
            end else if (c < 16'h0800) begin
                if (int'(stored) + 2 < int'(capacity)) begin
                    stored++;
                    emit({3'b110, c[10:6]}, jsu_pkg::KIND_BYTE);
                    stored++;
                    emit({2'b10, c[5:0]}, jsu_pkg::KIND_BYTE);
                end
            end else begin
                if (int'(stored) + 3 < int'(capacity)) begin
                    stored++;
                    emit({4'b1110, c[15:12]}, jsu_pkg::KIND_BYTE);
                    stored++;
                    emit({2'b10, c[11:6]}, jsu_pkg::KIND_BYTE);
                    stored++;
                    emit({2'b10, c[5:0]}, jsu_pkg::KIND_BYTE);
                end
            end
        endfunction

        function void close_string(logic [1:0] kind);
            emit(8'h00, kind);
            phase   = jsu_pkg::PH_IDLE;
            hex_cnt = '0;
            code    = '0;
            stored  = '0;
        endfunction

        // Decode one accepted text byte and queue its results
        function void take_text_byte(logic [7:0] b);
            int d;
            batch.delete();
            case (phase)
                jsu_pkg::PH_IDLE: begin
                    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                    end else if (b == CH_QUOTE) begin
                        phase  = jsu_pkg::PH_STR;
                        stored = '0;
                    end else begin
                        close_string(jsu_pkg::KIND_FAIL);
                    end
                end
                jsu_pkg::PH_STR: begin
                    if (b == CH_NUL) close_string(jsu_pkg::KIND_FAIL);
                    else if (b == CH_QUOTE) close_string(jsu_pkg::KIND_OK);
                    else if (b == CH_BSLASH) phase = jsu_pkg::PH_ESC;
                    else store_byte(b);
                end
                jsu_pkg::PH_ESC: begin
                    if (b == CH_NUL) begin
                        // dangling backslash is kept as a literal
                        store_byte(CH_BSLASH);
                        close_string(jsu_pkg::KIND_FAIL);
                    end else begin
                        phase = jsu_pkg::PH_STR;
                        case (b)
                            CH_N: store_byte(CH_LF);
                            CH_T: store_byte(CH_TAB);
                            CH_R: store_byte(CH_CR);
                            CH_B: store_byte(CH_BS);
                            CH_F: store_byte(CH_FF);
                            CH_U: begin
                                phase   = jsu_pkg::PH_HEX;
                                hex_cnt = '0;
                                code    = '0;
                            end
                            default: store_byte(b);
                        endcase
                    end
                end
                default: begin
                    if (b == CH_NUL) begin
                        // partial code still goes out before the failure
                        store_code(code);
                        close_string(jsu_pkg::KIND_FAIL);
                    end else begin
                        d = hex_digit(b);
                        if (d < 0) begin
                            close_string(jsu_pkg::KIND_FAIL);
                        end else begin
                            code = {code[11:0], d[3:0]};
                            if (hex_cnt == 2'd3) begin
                                hex_cnt = '0;
                                phase   = jsu_pkg::PH_STR;
                                store_code(code);
                                code    = '0;
                            end else begin
                                hex_cnt++;
                            end
                        end
                    end
                end
            endcase
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) expected_out.push_back(batch[i]);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_out.size() == 0) begin
                report($sformatf("unexpected result: byte %02h kind %0d length %0d last %0d",
                                 got.data, got.kind, got.length, got.last));
                return;
            end
            want = expected_out.pop_front();
            if (got.data !== want.data || got.kind !== want.kind ||
                got.length !== want.length || got.last !== want.last) begin
                report($sformatf({"result mismatch: expected byte %02h kind %0d length %0d ",
                                  "last %0d, got byte %02h kind %0d length %0d last %0d"},
                                 want.data, want.kind, want.length, want.last,
                                 got.data, got.kind, got.length, got.last));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, APB and the core
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    jsu_in_if  text_if ();
    jsu_out_if res_if ();

    json_string_unescape_utf8_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_if.sink),
        .o_out   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_scoreboard        sb;
    int                 long_hold_req = 0;
    int                 burst_left    = 0;
    bit                 bursty        = 1'b0;
    int                 phase_bytes   = 0;
    logic [7:0]         text_q[$];

    // ------------------------------------------------------------------------
    // Monitor: check results, then feed accepted text bytes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                sb.check_result('{data: res_if.out_byte, kind: res_if.out_kind,
                                  length: res_if.out_length, last: res_if.last});
            end
            if (text_if.valid && text_if.ready) sb.take_text_byte(text_if.in_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus long hold-offs on request
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode mode;
        int       left;
        int       hold;
        mode = RX_FLOW;
        left = 0;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req > 0) begin
                hold          = long_hold_req;
                long_hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(5, 40);
                end
                left--;
                case (mode)
                    RX_FLOW:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb_json_string_unescape_utf8_core NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (bursty) begin
                text_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        text_if.valid   <= 1'b1;
        text_if.in_byte <= b;
        do @(posedge i_clk); while (!text_if.ready);
        phase_bytes++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i]);
        text_q.delete();
    endtask

    // Stop sending and wait until every owed result has come out
    task automatic wait_drained();
        text_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_out.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAPACITY_ADDR) sb.set_capacity(data[15:0]);
        @(posedge i_clk);
    endtask

    task automatic apb_check_capacity();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAPACITY_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0000, sb.capacity}) begin
            sb.report($sformatf("capacity read back: expected %04h, got %08h",
                                sb.capacity, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Text builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        if ($urandom_range(0, 1) == 1) return 8'("a") + 8'(nib) - 8'd10;
        return 8'("A") + 8'(nib) - 8'd10;
    endfunction

    function automatic void push_hex_escape(logic [15:0] c, int digits);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 0; i < digits; i++) text_q.push_back(hex_char(c[15-4*i -: 4]));
    endfunction

    function automatic logic [15:0] random_code();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(16'h0000, 16'h007f));
            1:       return 16'($urandom_range(16'h0080, 16'h07ff));
            default: return 16'($urandom_range(16'h0800, 16'hffff));
        endcase
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (hex_digit(b) >= 0) b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    function automatic void push_token();
        logic [7:0] ctrl_names[5];
        logic [7:0] b;
        ctrl_names = '{CH_N, CH_T, CH_R, CH_B, CH_F};
        case (t_token'($urandom_range(0, 3)))
            TOK_PLAIN: begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
                text_q.push_back(b);
            end
            TOK_CTRL_ESC: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(ctrl_names[$urandom_range(0, 4)]);
            end
            TOK_OTHER_ESC: begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_U) b = CH_QUOTE;
                text_q.push_back(CH_BSLASH);
                text_q.push_back(b);
            end
            default: push_hex_escape(random_code(), 4);
        endcase
    endfunction

    // Mostly well-formed strings with random content; some end badly
    function automatic void push_string();
        logic [7:0]  blanks[4];
        t_string_end how;
        int          r;
        blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        repeat ($urandom_range(0, 2)) text_q.push_back(blanks[$urandom_range(0, 3)]);
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) push_token();
        r = $urandom_range(0, 19);
        if (r < 14) how = END_CLOSE;
        else if (r < 16) how = END_NUL;
        else if (r < 17) how = END_ESC_NUL;
        else if (r < 19) how = END_HEX_NUL;
        else how = END_BAD_HEX;
        case (how)
            END_CLOSE: text_q.push_back(CH_QUOTE);
            END_NUL:   text_q.push_back(CH_NUL);
            END_ESC_NUL: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_NUL);
            end
            END_HEX_NUL: begin
                push_hex_escape(random_code(), $urandom_range(0, 3));
                text_q.push_back(CH_NUL);
            end
            default: begin
                push_hex_escape(random_code(), $urandom_range(0, 3));
                text_q.push_back(bad_hex_char());
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] caps[10];
        sb = new();
        sb.reset_state();
        sb.errors       = 0;
        text_if.valid   = 1'b0;
        text_if.in_byte = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_check_capacity();

        // Directed: stray byte before quote, blanks, escapes, 2- and 3-byte
        // codes, backslash at NUL, NUL inside hex digits, bad hex digit
        text_q = '{"x", CH_TAB, CH_SPACE, CH_QUOTE, "A", CH_BSLASH, CH_N,
                   CH_BSLASH, CH_U, "0", "0", "e", "9",
                   CH_BSLASH, CH_U, "F", "f", "F", "f", CH_QUOTE,
                   CH_CR, CH_LF, CH_QUOTE, CH_BSLASH, CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_U, "4", CH_NUL,
                   CH_QUOTE, CH_BSLASH, CH_U, "g"};
        send_text();
        wait_drained();

        caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hffff,
                 16'($urandom_range(5, 40)), 16'd7, 16'($urandom_range(0, 65535)), 16'd32};

        // Random phases, one capacity each
        foreach (caps[p]) begin
            apb_write(CAPACITY_ADDR, {16'h0000, caps[p]});
            apb_check_capacity();
            bursty      = (p % 3 != 0);
            phase_bytes = 0;
            if (p == 3) long_hold_req = LONG_HOLD;
            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    push_string();
                end
                send_text();
                if (p == 7 && phase_bytes >= PHASE_BYTES / 2 && phase_bytes < PHASE_BYTES)
                    wait_drained();
            end
            // leave a string open so the next capacity lands mid-string
            if (p % 2 == 1) begin
                text_q = '{CH_QUOTE, "a", "b", "c", "d", "e"};
                send_text();
            end
            wait_drained();
        end

        if (sb.expected_out.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expected_out.size()));
        if (sb.errors == 0) begin
            $display("tb_json_string_unescape_utf8_core OK");
        end else begin
            $display("tb_json_string_unescape_utf8_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== json_string_unescape_utf8_core.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_in_if.sv
rtl/core/jsu_out_if.sv
rtl/core/jsu_cfg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_out_buf.sv
rtl/core/json_string_unescape_utf8_core.sv
bench/tb_json_string_unescape_utf8_core.sv
